### src/csvt_pkg.sv
// Shared types, constants and the per-byte tokenizer step for the CSV tokenizer.
// No dependencies; all files but csvt_stream_if import this package.
package csvt_pkg;

	// Widest row that still gets distinct column indexes
	localparam int MAX_COLUMNS = 256;
	localparam logic [7:0] COL_CAP = (MAX_COLUMNS - 1 < 255) ? 8'(MAX_COLUMNS - 1) : 8'd255;

	// Results one byte can cause, and the default depth of the result queue
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int QUEUE_DEPTH_DFLT = 4;

	localparam logic [7:0] CH_BOM0  = 8'hEF;
	localparam logic [7:0] CH_BOM1  = 8'hBB;
	localparam logic [7:0] CH_BOM2  = 8'hBF;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EOF  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		QM_UNQUOTED = 2'd0,
		QM_QUOTED   = 2'd1,
		QM_PENDING  = 2'd2
	} quote_mode_t;

	typedef enum logic [1:0] {
		BOM_START = 2'd0,
		BOM_EF    = 2'd1,
		BOM_EFBB  = 2'd2,
		BOM_PAST  = 2'd3
	} bom_stage_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       row_end;
		logic [7:0] column;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       row_end;
		logic [7:0] column;
	} result_t;

	// All results caused by one input byte, packed from index 0
	typedef struct packed {
		result_t [MAX_RES-1:0]  res;
		logic [RES_CNT_W-1:0]   count;
	} bundle_t;

	typedef struct packed {
		quote_mode_t quote_mode;
		logic        field_empty;
		logic [7:0]  column;
		logic        skip_lf;
	} tok_state_t;

	typedef struct packed {
		tok_state_t st;
		logic       hit;
		result_t    res;
	} take_ret_t;

	// One byte through the field/row state; at most one result
	function automatic take_ret_t take_byte(input tok_state_t s, input logic [7:0] c);
		take_ret_t r;
		r.st = s;
		r.st.skip_lf = 1'b0;
		r.hit = 1'b0;
		r.res.kind = KIND_DATA;
		r.res.data_byte = c;
		r.res.row_end = 1'b0;
		r.res.column = s.column;
		if (s.skip_lf && c == CH_LF) begin
			// drop the LF of a CRLF
			r.hit = 1'b0;
		end else if (s.quote_mode == QM_QUOTED) begin
			if (c == CH_QUOTE) begin
				r.st.quote_mode = QM_PENDING;
			end else begin
				r.hit = 1'b1;
				r.st.field_empty = 1'b0;
			end
		end else if (s.quote_mode == QM_PENDING && c == CH_QUOTE) begin
			r.hit = 1'b1;
			r.st.field_empty = 1'b0;
			r.st.quote_mode = QM_QUOTED;
		end else begin
			r.st.quote_mode = QM_UNQUOTED;
			if (c == CH_QUOTE && s.field_empty) begin
				r.st.quote_mode = QM_QUOTED;
			end else if (c == CH_COMMA) begin
				r.hit = 1'b1;
				r.res.kind = KIND_EOF;
				r.res.data_byte = '0;
				if (s.column < COL_CAP)
					r.st.column = s.column + 8'd1;
				r.st.field_empty = 1'b1;
			end else if (c == CH_CR || c == CH_LF) begin
				r.st.skip_lf = (c == CH_CR);
				// a row that is one empty field gives nothing
				r.hit = !(s.column == '0 && s.field_empty);
				r.res.kind = KIND_EOF;
				r.res.data_byte = '0;
				r.res.row_end = 1'b1;
				r.st.column = '0;
				r.st.field_empty = 1'b1;
			end else begin
				r.hit = 1'b1;
				r.st.field_empty = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

### src/csvt_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is a parameter; the CSV tokenizer uses the types of csvt_pkg.
interface csvt_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### src/csvt_front.sv
// Front end of the CSV tokenizer: accepts bytes, tracks mark/quote/field state,
// and packs each byte's results in one bundle. Needs csvt_pkg, csvt_stream_if.
module csvt_front
	import csvt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	csvt_stream_if.sink   byte_in,
	input  logic          full,
	output logic          push,
	output bundle_t       push_bundle
);

	tok_state_t  st_q;
	bom_stage_t  bom_q;
	tok_state_t  st_n;
	bom_stage_t  bom_n;

	logic        accept;
	logic [7:0]  c;
	logic        fin;
	logic [7:0]  feed [3];
	logic [2:0]  feed_en;
	take_ret_t   tr [3];
	tok_state_t  chain [4];
	result_t     slot [MAX_RES];
	logic [MAX_RES-1:0] slot_hit;

	assign byte_in.ready = !full;
	assign accept = byte_in.valid && byte_in.ready;
	assign c   = byte_in.payload.byte_value;
	assign fin = byte_in.payload.final_byte;

	// Pick the bytes to run through the state: held mark bytes first
	always_comb begin
		feed[0] = c;
		feed[1] = c;
		feed[2] = c;
		feed_en = 3'b000;
		bom_n   = BOM_PAST;
		case (bom_q)
			BOM_START: begin
				if (c == CH_BOM0) begin
					bom_n = BOM_EF;
					if (fin) begin
						feed[0] = CH_BOM0;
						feed_en = 3'b001;
					end
				end else begin
					feed_en = 3'b001;
				end
			end
			BOM_EF: begin
				if (c == CH_BOM1) begin
					bom_n = BOM_EFBB;
					if (fin) begin
						feed[0] = CH_BOM0;
						feed[1] = CH_BOM1;
						feed_en = 3'b011;
					end
				end else begin
					feed[0] = CH_BOM0;
					feed_en = 3'b011;
				end
			end
			BOM_EFBB: begin
				if (c != CH_BOM2) begin
					feed[0] = CH_BOM0;
					feed[1] = CH_BOM1;
					feed_en = 3'b111;
				end
			end
			default: begin
				feed_en = 3'b001;
			end
		endcase
	end

	// Chain of up to three byte steps, then the end-of-file check
	always_comb begin
		chain[0] = st_q;
		for (int i = 0; i < 3; i++) begin
			tr[i] = take_byte(chain[i], feed[i]);
			chain[i+1] = feed_en[i] ? tr[i].st : chain[i];
			slot[i] = tr[i].res;
			slot_hit[i] = feed_en[i] && tr[i].hit;
		end
		slot[3].kind = KIND_EOF;
		slot[3].data_byte = '0;
		slot[3].row_end = 1'b1;
		slot[3].column = chain[3].column;
		slot_hit[3] = 1'b0;
		st_n = chain[3];
		if (fin) begin
			if (chain[3].quote_mode == QM_QUOTED) begin
				slot[3].kind = KIND_ERR;
				slot[3].row_end = 1'b0;
				slot_hit[3] = 1'b1;
			end else begin
				slot_hit[3] = !chain[3].field_empty || chain[3].column != '0;
			end
			st_n.quote_mode = QM_UNQUOTED;
			st_n.field_empty = 1'b1;
			st_n.column = '0;
			st_n.skip_lf = 1'b0;
		end
	end

	// Pack the hits to the low slots
	always_comb begin
		push_bundle = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			if (slot_hit[i]) begin
				push_bundle.res[push_bundle.count[RES_IDX_W-1:0]] = slot[i];
				push_bundle.count = push_bundle.count + 1'b1;
			end
		end
	end

	assign push = accept && push_bundle.count != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.quote_mode  <= QM_UNQUOTED;
			st_q.field_empty <= 1'b1;
			st_q.column      <= '0;
			st_q.skip_lf     <= 1'b0;
			bom_q            <= BOM_START;
		end else if (accept) begin
			st_q  <= st_n;
			bom_q <= fin ? BOM_START : bom_n;
		end
	end

	a_fin_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fin |=> bom_q == BOM_START && st_q.column == '0 && st_q.field_empty)
		else $error("state not back at file start after final byte");

endmodule

### src/csvt_queue.sv
// Short queue of result bundles between the tokenizer front and back ends.
// Depends on csvt_pkg for the bundle type.
module csvt_queue
	import csvt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_bundle,
	output logic    full,
	input  logic    pop,
	output bundle_t head,
	output logic    head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

### src/csvt_back.sv
// Back end of the CSV tokenizer: walks the head bundle one result a beat into
// the output register. Depends on csvt_pkg and csvt_stream_if.
module csvt_back
	import csvt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  bundle_t       head,
	input  logic          head_valid,
	output logic          pop,
	csvt_stream_if.source token_out
);

	logic [RES_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic                 load;
	logic                 last;
	result_t              cur;

	assign cur  = head.res[idx_q];
	assign last = RES_CNT_W'(idx_q) == head.count - 1'b1;
	assign load = head_valid && (!out_valid_q || token_out.ready);
	assign pop  = load && last;

	assign token_out.valid   = out_valid_q;
	assign token_out.payload = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.kind      <= cur.kind;
			out_q.data_byte <= cur.data_byte;
			out_q.row_end   <= cur.row_end;
			out_q.column    <= cur.column;
			out_q.run_last  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (token_out.ready)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> RES_CNT_W'(idx_q) < head.count)
		else $error("result index past bundle count");

endmodule

### src/csv_stream_tokenizer_core.sv
// Top level of the CSV stream tokenizer: front end, bundle queue, back end.
// Depends on csvt_pkg, csvt_stream_if, csvt_front, csvt_queue and csvt_back.
//
// Usage:
//   byte_in takes one file byte per beat (byte_value, final_byte). Raise
//   final_byte on the last byte of each file; the block then returns to its
//   file-start state and the next beat starts a new file.
//   token_out gives one result per beat: field data bytes, end-of-field
//   markers (row_end, column) and the unclosed-quote error. run_last marks the
//   last result caused by one input byte; a byte may cause none, up to four.
// Timing:
//   The front end decides all results of a byte in the cycle it is accepted
//   and writes them as one bundle into a queue of QUEUE_DEPTH entries. The
//   first result of a byte goes from the queue head into the output
//   register that drives token_out. Input runs at one byte per cycle;
//   output at one result per cycle while token_out.ready is high, each
//   result of a byte taking its own beat, and the input is held off only
//   when the queue is full.
// Stalls and reset:
//   While token_out.ready is low the output beat holds and the queue fills;
//   byte_in.ready drops once all QUEUE_DEPTH entries are in use.
//   arst_n empties the queue and output register and puts the parser at file
//   start (no mark seen, unquoted, column 0).
module csv_stream_tokenizer_core
	import csvt_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
	input  logic          clk,
	input  logic          arst_n,
	csvt_stream_if.sink   byte_in,
	csvt_stream_if.source token_out
);

	logic    push;
	logic    full;
	logic    pop;
	logic    head_valid;
	bundle_t push_bundle;
	bundle_t head;

	// Classify each byte and build its result bundle
	csvt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.full        (full),
		.push        (push),
		.push_bundle (push_bundle)
	);

	// Decouple byte intake from result delivery
	csvt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.full        (full),
		.pop         (pop),
		.head        (head),
		.head_valid  (head_valid)
	);

	// Drain bundles one result per beat
	csvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.token_out  (token_out)
	);

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid && token_out.payload.kind == KIND_ERR |-> token_out.payload.run_last)
		else $error("error result not last of its byte");

	a_data_no_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid && token_out.payload.kind == KIND_DATA |-> !token_out.payload.row_end)
		else $error("data beat flagged as row end");

endmodule
